// ===== rtl/spc_pkg.sv =====
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the signaling packet classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

	typedef enum logic [5:0] {
		ST_ETH  = 6'b000001,
		ST_TAG  = 6'b000010,
		ST_V4   = 6'b000100,
		ST_V6   = 6'b001000,
		ST_L4   = 6'b010000,
		ST_SKIP = 6'b100000
	} stage_t;

	typedef enum logic [2:0] {
		RSN_MATCH    = 3'd0,
		RSN_RUNT     = 3'd1,
		RSN_L3       = 3'd2,
		RSN_IHL      = 3'd3,
		RSN_FRAG     = 3'd4,
		RSN_L4_SHORT = 3'd5,
		RSN_PROTO    = 3'd6,
		RSN_NO_PORT  = 3'd7
	} reason_t;

	localparam logic [15:0] ET_VLAN = 16'h8100;
	localparam logic [15:0] ET_QINQ = 16'h88a8;
	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86dd;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_SCTP = 8'd132;

	localparam logic [15:0] PORT_S1AP = 16'd36412;
	localparam logic [15:0] PORT_GTPC = 16'd2123;
	localparam logic [15:0] PORT_DIAM = 16'd3868;
	localparam logic [15:0] PORT_PFCP = 16'd8805;
	localparam logic [15:0] PORT_GTPU = 16'd2152;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// frame summary handed from parser to verdict stage
	typedef struct packed {
		stage_t      stage;
		logic        rem_lt20;
		logic        rem_lt4;
		logic        frag;
		logic [7:0]  proto;
		logic [15:0] src_port;
		logic [15:0] dst_port;
	} summary_t;

	function automatic stage_t stage_for_type(input logic [15:0] et);
		stage_t s;
		s = ST_SKIP;
		if (et == ET_VLAN || et == ET_QINQ) begin
			s = ST_TAG;
		end else if (et == ET_IPV4) begin
			s = ST_V4;
		end else if (et == ET_IPV6) begin
			s = ST_V6;
		end
		return s;
	endfunction

endpackage

// ===== rtl/spc_front.sv =====
// ----------------------------------------------------------------------------
// spc_front
// Byte parser: walks L2 tags, IPv4/IPv6 and L4 ports, one byte per cycle while
// in_ready is high, and pushes a frame summary on the last byte.
// ----------------------------------------------------------------------------
module spc_front #(
	parameter int MAX_FRAME_BYTES = 65535
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              push,
	output spc_pkg::summary_t sum
);
	import spc_pkg::*;

	localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);

	logic [OFF_W-1:0] off_q, off_n, l3_q, l3_n, k, rem;
	stage_t           stage_q, stage_n;
	logic [15:0]      et_q, et_n, src_q, src_n, dst_q, dst_n;
	logic [5:0]       ihl_q, ihl_n;
	logic             frag_q, frag_n;
	logic [7:0]       proto_q, proto_n;
	logic             acc;

	assign acc = in_valid && in_ready;
	assign k   = off_q - l3_q;

	always_comb begin
		off_n   = off_q;
		l3_n    = l3_q;
		stage_n = stage_q;
		et_n    = et_q;
		ihl_n   = ihl_q;
		frag_n  = frag_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		if (off_q < OFF_MAX) begin
			off_n = off_q + OFF_W'(1);
			case (stage_q)
				ST_ETH: begin
					if (off_q == OFF_W'(12)) et_n = {in_byte, 8'h00};
					if (off_q == OFF_W'(13)) begin
						et_n    = {et_q[15:8], in_byte};
						l3_n    = OFF_W'(14);
						stage_n = stage_for_type({et_q[15:8], in_byte});
					end
				end
				ST_TAG: begin
					if (k == OFF_W'(2)) et_n = {in_byte, 8'h00};
					if (k == OFF_W'(3)) begin
						et_n    = {et_q[15:8], in_byte};
						l3_n    = off_q + OFF_W'(1);
						stage_n = stage_for_type({et_q[15:8], in_byte});
					end
				end
				ST_V4: begin
					if (k == OFF_W'(0)) ihl_n = {in_byte[3:0], 2'b00};
					if (k == OFF_W'(6) && in_byte[4:0] != 5'd0) frag_n = 1'b1;
					if (k == OFF_W'(7) && in_byte != 8'd0) frag_n = 1'b1;
					if (k == OFF_W'(9)) proto_n = in_byte;
					if (k >= OFF_W'(19) && ihl_q >= 6'd20 &&
					    k + OFF_W'(1) == OFF_W'(ihl_q)) begin
						l3_n    = off_q + OFF_W'(1);
						stage_n = ST_L4;
					end
				end
				ST_V6: begin
					if (k == OFF_W'(6)) proto_n = in_byte;
					if (k == OFF_W'(39)) begin
						l3_n    = off_q + OFF_W'(1);
						stage_n = ST_L4;
					end
				end
				ST_L4: begin
					if (k == OFF_W'(0)) src_n = {in_byte, src_q[7:0]};
					if (k == OFF_W'(1)) src_n = {src_q[15:8], in_byte};
					if (k == OFF_W'(2)) dst_n = {in_byte, dst_q[7:0]};
					if (k == OFF_W'(3)) dst_n = {dst_q[15:8], in_byte};
				end
				default: begin
				end
			endcase
		end
	end

	assign rem  = off_n - l3_n;
	assign push = acc && in_last;

	always_comb begin
		sum.stage    = stage_n;
		sum.rem_lt20 = rem < OFF_W'(20);
		sum.rem_lt4  = rem < OFF_W'(4);
		sum.frag     = frag_n;
		sum.proto    = proto_n;
		sum.src_port = src_n;
		sum.dst_port = dst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			l3_q    <= '0;
			stage_q <= ST_ETH;
			et_q    <= '0;
			ihl_q   <= '0;
			frag_q  <= 1'b0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else if (acc) begin
			if (in_last) begin
				off_q   <= '0;
				l3_q    <= '0;
				stage_q <= ST_ETH;
				et_q    <= '0;
				ihl_q   <= '0;
				frag_q  <= 1'b0;
				proto_q <= '0;
				src_q   <= '0;
				dst_q   <= '0;
			end else begin
				off_q   <= off_n;
				l3_q    <= l3_n;
				stage_q <= stage_n;
				et_q    <= et_n;
				ihl_q   <= ihl_n;
				frag_q  <= frag_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
			end
		end
	end

	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		off_q <= OFF_MAX) else $error("byte offset past frame limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (off_q == '0 && stage_q == ST_ETH && !frag_q))
		else $error("parser not cleared after last byte");

	a_l3_behind: assert property (@(posedge clk) disable iff (!arst_n)
		l3_q <= off_q) else $error("header start ahead of offset");

endmodule

// ===== rtl/spc_queue.sv =====
// ----------------------------------------------------------------------------
// spc_queue
// Small FIFO of frame summaries between parser and verdict stage.
// ----------------------------------------------------------------------------
module spc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spc_pkg::summary_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              rd_valid,
	output spc_pkg::summary_t rd_data
);
	import spc_pkg::*;

	summary_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd_valid) else $error("pop from empty queue");

endmodule

// ===== rtl/spc_back.sv =====
// ----------------------------------------------------------------------------
// spc_back
// Verdict stage: turns a frame summary into match flag and reason code
// and holds it in the output register.
// ----------------------------------------------------------------------------
module spc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              user_plane,
	input  logic              q_valid,
	input  spc_pkg::summary_t q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_match,
	output logic [2:0]        out_reason
);
	import spc_pkg::*;

	reason_t rsn;
	logic    any_ctrl, has_s1ap, has_gtpu;
	logic    valid_q, match_q;
	reason_t rsn_q;

	assign has_s1ap = q_data.src_port == PORT_S1AP || q_data.dst_port == PORT_S1AP;
	assign has_gtpu = q_data.src_port == PORT_GTPU || q_data.dst_port == PORT_GTPU;
	assign any_ctrl = q_data.src_port == PORT_GTPC || q_data.dst_port == PORT_GTPC ||
	                  q_data.src_port == PORT_DIAM || q_data.dst_port == PORT_DIAM ||
	                  q_data.src_port == PORT_PFCP || q_data.dst_port == PORT_PFCP;

	always_comb begin
		case (q_data.stage)
			ST_ETH: rsn = RSN_RUNT;
			ST_V4:  rsn = q_data.rem_lt20 ? RSN_L3 : RSN_IHL;
			ST_L4: begin
				if (q_data.frag) rsn = RSN_FRAG;
				else if (q_data.rem_lt4) rsn = RSN_L4_SHORT;
				else if (q_data.proto == PROTO_SCTP) rsn = has_s1ap ? RSN_MATCH : RSN_NO_PORT;
				else if (q_data.proto != PROTO_UDP && q_data.proto != PROTO_TCP)
					rsn = RSN_PROTO;
				else if (any_ctrl || (user_plane && has_gtpu)) rsn = RSN_MATCH;
				else rsn = RSN_NO_PORT;
			end
			default: rsn = RSN_L3;
		endcase
	end

	assign pop = q_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsn_q   <= rsn;
			match_q <= rsn == RSN_MATCH;
		end
	end

	assign out_valid  = valid_q;
	assign out_match  = match_q;
	assign out_reason = rsn_q;

	a_match_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (match_q == (rsn_q == RSN_MATCH)))
		else $error("match flag disagrees with reason");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q) else $error("popped summary lost");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !pop) else $error("pop over stalled result");

endmodule

// ===== rtl/signaling_packet_classifier.sv =====
// ----------------------------------------------------------------------------
// signaling_packet_classifier
// Classifies Ethernet frames as control-plane signaling by L4 port.
//
// Input stream (s_*): one frame byte per transfer, s_tlast on the final byte.
// Output stream (m_*): one verdict per frame, m_tdata[0] is_signaling,
//   m_tdata[3:1] reason code.
// cfg_wr_en/cfg_wr_data write include_user_plane (GTP-U 2152 accepted when 1).
// Throughput: one byte per cycle sustained while s_tready is high, frames back to back.
// After the last-byte transfer the frame summary is written into the queue and
//   then into the output register, where the verdict appears.
// A 4-entry summary queue sits between parser and verdict stage; s_tready
//   drops only when it is full, i.e. once four verdicts wait behind the one
//   held in the stalled output register (five frame ends under stall).
// Reset clears the parser, the queue, the output valid and the include_user_plane register;
// no flush pass is needed.
// ----------------------------------------------------------------------------
module signaling_packet_classifier #(
	parameter int MAX_FRAME_BYTES = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] frame_byte
	input  logic       s_tlast,   // end_of_frame
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] is_signaling, [3:1] verdict_reason, [7:4] zero
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);
	import spc_pkg::*;

	logic       user_plane_q;
	logic       push, full, pop, q_valid, match;
	logic [2:0] reason;
	summary_t   wr_sum, rd_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_plane_q <= 1'b0;
		end else if (cfg_wr_en) begin
			user_plane_q <= cfg_wr_data;
		end
	end

	assign s_tready = !full;

	spc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.sum      (wr_sum)
	);

	spc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (wr_sum),
		.full     (full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_data  (rd_sum)
	);

	spc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.user_plane (user_plane_q),
		.q_valid    (q_valid),
		.q_data     (rd_sum),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_match  (match),
		.out_reason (reason)
	);

	assign m_tdata = {4'b0000, reason, match};

endmodule
